// ===== sv/mcoc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcoc_pkg
// Shared constants and codes of the mip chain offset calculator.
// ----------------------------------------------------------------------------
package mcoc_pkg;

	localparam int LEVEL_BITS   = 5;
	localparam int LEVELS       = 32;
	localparam int LENGTH_BITS  = 35;
	localparam int REG_IDX_BITS = 3;

	typedef enum logic [1:0] {
		FMT_BC1   = 2'd0,
		FMT_BC2   = 2'd1,
		FMT_BC3   = 2'd2,
		FMT_BGRA8 = 2'd3
	} fmt_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_BASE_WIDTH    = 3'd0,
		REG_BASE_HEIGHT   = 3'd1,
		REG_PIXEL_FORMAT  = 3'd2,
		REG_LEVEL_COUNT   = 3'd3,
		REG_PAYLOAD_BYTES = 3'd4
	} reg_idx_t;

endpackage

// ===== sv/mcoc_table.sv =====
// ----------------------------------------------------------------------------
// mcoc_table
// Level table: sweeps all mip levels after reset or a restart, storing each level's
// byte length and running offset; one registered read port for lookups.
// ----------------------------------------------------------------------------
module mcoc_table #(
	parameter int DIM_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    restart,
	input  logic [DIM_BITS-1:0]                     base_width,
	input  logic [DIM_BITS-1:0]                     base_height,
	input  mcoc_pkg::fmt_t                          pixel_format,
	output logic                                    busy,
	input  logic                                    rd_en,
	input  logic [mcoc_pkg::LEVEL_BITS-1:0]         rd_addr,
	output logic [2*DIM_BITS+2+mcoc_pkg::LEVEL_BITS-1:0] rd_offset,
	output logic [2*DIM_BITS+2-1:0]                 rd_length
);

	localparam int LEN_W  = 2*DIM_BITS + 2;
	localparam int ACC_W  = LEN_W + mcoc_pkg::LEVEL_BITS;
	localparam int PROD_W = 2*DIM_BITS;
	localparam logic [mcoc_pkg::LEVEL_BITS-1:0] LAST =
		mcoc_pkg::LEVEL_BITS'(mcoc_pkg::LEVELS - 1);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                          state_q;
	logic [mcoc_pkg::LEVEL_BITS-1:0] cnt_q;
	logic                            issue_q;
	logic                            a_vld_q;
	logic [mcoc_pkg::LEVEL_BITS-1:0] a_idx_q;
	logic [DIM_BITS-1:0]             a_bw_q;
	logic [DIM_BITS-1:0]             a_bh_q;
	logic                            b_vld_q;
	logic [mcoc_pkg::LEVEL_BITS-1:0] b_idx_q;
	logic [PROD_W-1:0]               b_prod_q;
	logic [ACC_W-1:0]                acc_q;
	logic [ACC_W+LEN_W-1:0]          mem [mcoc_pkg::LEVELS];
	logic [ACC_W+LEN_W-1:0]          rd_q;

	logic [DIM_BITS-1:0] bw_c;
	logic [DIM_BITS-1:0] bh_c;
	logic [LEN_W-1:0]    prod_ext;
	logic [LEN_W-1:0]    len_c;
	logic                issuing;

	function automatic logic [DIM_BITS-1:0] blocks(
		input logic [DIM_BITS-1:0] dim,
		input logic [mcoc_pkg::LEVEL_BITS-1:0] lvl,
		input mcoc_pkg::fmt_t fmt
	);
		logic [DIM_BITS-1:0] d;
		logic [DIM_BITS:0]   r;
		d = dim >> lvl;
		if (d == '0) begin
			d = DIM_BITS'(1);
		end
		r = {1'b0, d} + (DIM_BITS+1)'(3);
		if (fmt == mcoc_pkg::FMT_BGRA8) begin
			blocks = d;
		end else begin
			blocks = DIM_BITS'(r[DIM_BITS:2]);
		end
	endfunction

	assign issuing  = (state_q == ST_RUN) && issue_q;
	assign bw_c     = blocks(base_width, cnt_q, pixel_format);
	assign bh_c     = blocks(base_height, cnt_q, pixel_format);
	assign prod_ext = LEN_W'(b_prod_q);

	always_comb begin
		unique case (pixel_format)
			mcoc_pkg::FMT_BC1:   len_c = prod_ext << 3;
			mcoc_pkg::FMT_BC2:   len_c = prod_ext << 4;
			mcoc_pkg::FMT_BC3:   len_c = prod_ext << 4;
			mcoc_pkg::FMT_BGRA8: len_c = prod_ext << 2;
			default:             len_c = prod_ext << 4;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			issue_q <= 1'b1;
			a_vld_q <= 1'b0;
			b_vld_q <= 1'b0;
			acc_q   <= '0;
		end else if (restart) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			issue_q <= 1'b1;
			a_vld_q <= 1'b0;
			b_vld_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			a_vld_q <= issuing;
			b_vld_q <= a_vld_q;
			if (issuing) begin
				cnt_q <= cnt_q + mcoc_pkg::LEVEL_BITS'(1);
				if (cnt_q == LAST) begin
					issue_q <= 1'b0;
				end
			end
			if (b_vld_q) begin
				acc_q <= acc_q + ACC_W'(len_c);
				if (b_idx_q == LAST) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		a_idx_q  <= cnt_q;
		a_bw_q   <= bw_c;
		a_bh_q   <= bh_c;
		b_idx_q  <= a_idx_q;
		b_prod_q <= a_bw_q * a_bh_q;
	end

	always_ff @(posedge clk) begin
		if (b_vld_q) begin
			mem[b_idx_q] <= {acc_q, len_c};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign busy      = (state_q == ST_RUN);
	assign rd_offset = rd_q[ACC_W+LEN_W-1:LEN_W];
	assign rd_length = rd_q[LEN_W-1:0];

endmodule

// ===== sv/mip_chain_offset_calc_unit.sv =====
// ----------------------------------------------------------------------------
// mip_chain_offset_calc_unit
// Byte offset, length and validity of one mip level inside a texture payload.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  query    | in        | in_valid / in_ready  | level
//  result   | out       | out_valid / out_ready| level_offset, level_length,
//           |           |                      | level_valid
//  config   | in        | cfg_we (no wait)     | cfg_index, cfg_wdata
//
//  Three-stage pipeline: level capture, table read, end check. One query per
//  cycle is sustained while the table is idle and out_ready is high.
//  After reset and after every config write the level table is rebuilt by a
//  32-level sweep; in_ready stays low while it runs.
//  A stalled output holds the pipeline back stage by stage; nothing is lost.
// ----------------------------------------------------------------------------
module mip_chain_offset_calc_unit #(
	parameter int DIM_BITS    = 16,
	parameter int OFFSET_BITS = 36
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mcoc_pkg::REG_IDX_BITS-1:0]   cfg_index,
	input  logic [OFFSET_BITS-1:0]              cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mcoc_pkg::LEVEL_BITS-1:0]     level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [OFFSET_BITS-1:0]              level_offset,
	output logic [mcoc_pkg::LENGTH_BITS-1:0]    level_length,
	output logic                                level_valid
);

	localparam int LEN_W = 2*DIM_BITS + 2;
	localparam int ACC_W = LEN_W + mcoc_pkg::LEVEL_BITS;
	localparam int CMP_W = ((ACC_W > OFFSET_BITS) ? ACC_W : OFFSET_BITS) + 1;

	logic [DIM_BITS-1:0]             base_width_q;
	logic [DIM_BITS-1:0]             base_height_q;
	mcoc_pkg::fmt_t                  pixel_format_q;
	logic [mcoc_pkg::LEVEL_BITS-1:0] level_count_q;
	logic [OFFSET_BITS-1:0]          payload_bytes_q;

	logic                            busy;
	logic [ACC_W-1:0]                rd_offset;
	logic [LEN_W-1:0]                rd_length;

	logic                            vld_s1, vld_s2, vld_s3;
	logic                            en_s1, en_s2, en_s3;
	logic [mcoc_pkg::LEVEL_BITS-1:0] lvl_s1;
	logic                            exists_s1, exists_s2;
	logic [OFFSET_BITS-1:0]          offset_s3;
	logic [mcoc_pkg::LENGTH_BITS-1:0] length_s3;
	logic                            ok_s3;

	logic [CMP_W-1:0]                end_c;
	logic                            ok_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q    <= DIM_BITS'(1);
			base_height_q   <= DIM_BITS'(1);
			pixel_format_q  <= mcoc_pkg::FMT_BC1;
			level_count_q   <= mcoc_pkg::LEVEL_BITS'(1);
			payload_bytes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcoc_pkg::REG_BASE_WIDTH:    base_width_q <= cfg_wdata[DIM_BITS-1:0];
				mcoc_pkg::REG_BASE_HEIGHT:   base_height_q <= cfg_wdata[DIM_BITS-1:0];
				mcoc_pkg::REG_PIXEL_FORMAT:  pixel_format_q <= mcoc_pkg::fmt_t'(cfg_wdata[1:0]);
				mcoc_pkg::REG_LEVEL_COUNT:
					level_count_q <= cfg_wdata[mcoc_pkg::LEVEL_BITS-1:0];
				mcoc_pkg::REG_PAYLOAD_BYTES: payload_bytes_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mcoc_table #(
		.DIM_BITS(DIM_BITS)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (cfg_we),
		.base_width   (base_width_q),
		.base_height  (base_height_q),
		.pixel_format (pixel_format_q),
		.busy         (busy),
		.rd_en        (en_s2),
		.rd_addr      (lvl_s1),
		.rd_offset    (rd_offset),
		.rd_length    (rd_length)
	);

	assign en_s3    = !vld_s3 || out_ready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1 && !busy;

	assign end_c = CMP_W'(rd_offset) + CMP_W'(rd_length);
	assign ok_c  = exists_s2 && (end_c <= CMP_W'(payload_bytes_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid && !busy;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			lvl_s1    <= level;
			exists_s1 <= level < level_count_q;
		end
		if (en_s2) begin
			exists_s2 <= exists_s1;
		end
		if (en_s3) begin
			ok_s3     <= ok_c;
			offset_s3 <= ok_c ? OFFSET_BITS'(rd_offset) : '0;
			length_s3 <= ok_c ? mcoc_pkg::LENGTH_BITS'(rd_length) : '0;
		end
	end

	assign out_valid    = vld_s3;
	assign level_offset = offset_s3;
	assign level_length = length_s3;
	assign level_valid  = ok_s3;

	// table rebuild must block queries right after a config write
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("query accepted during table rebuild");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !level_valid |-> level_offset == '0 && level_length == '0)
		else $error("invalid result carries nonzero fields");

	a_fits_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_valid |->
			(CMP_W'(level_offset) + CMP_W'(level_length)) <= CMP_W'(payload_bytes_q))
		else $error("valid level exceeds payload");

	a_busy_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !$past(busy) && $past(arst_n) |-> $past(cfg_we))
		else $error("table rebuild started without config write");

endmodule

// ===== bench/mip_chain_offset_calc_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mip_chain_offset_calc_unit_tb
// Drives level queries and register writes into the mip chain offset unit.
// Directed rows cover reset state, extreme sizes, every format, zero sizes,
// wide write data and unused register indexes. Random phases follow with fresh
// settings and varied flow control. Each result is checked against the row's
// expected values or a predictor of the level placement.
// ----------------------------------------------------------------------------
module mip_chain_offset_calc_unit_tb;

	localparam int DIM_W = 16;
	localparam int OFF_W = 36;
	localparam logic [mcoc_pkg::REG_IDX_BITS-1:0] REG_IDX_SPARE = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 160;

	typedef struct packed {
		logic [OFF_W-1:0]                 off;
		logic [mcoc_pkg::LENGTH_BITS-1:0] len;
		logic                             vld;
	} mip_place_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_QUERY
	} row_kind_t;

	typedef struct packed {
		row_kind_t                         kind;
		logic [mcoc_pkg::REG_IDX_BITS-1:0] idx;
		logic [OFF_W-1:0]                  data;
		logic [mcoc_pkg::LEVEL_BITS-1:0]   lvl;
		logic                              typed;
		mip_place_t                        want;
	} stim_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [mcoc_pkg::REG_IDX_BITS-1:0] cfg_index = '0;
	logic [OFF_W-1:0]                  cfg_wdata = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [mcoc_pkg::LEVEL_BITS-1:0]   level = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [OFF_W-1:0]                  level_offset;
	logic [mcoc_pkg::LENGTH_BITS-1:0]  level_length;
	logic                              level_valid;

	// shadow of the configuration registers
	logic [DIM_W-1:0]                cur_width = 16'd1;
	logic [DIM_W-1:0]                cur_height = 16'd1;
	mcoc_pkg::fmt_t                  cur_fmt = mcoc_pkg::FMT_BC1;
	logic [mcoc_pkg::LEVEL_BITS-1:0] cur_levels = 5'd1;
	logic [OFF_W-1:0]                cur_payload = '0;

	mip_place_t place_q[$];
	mip_place_t head;
	stim_row_t  stim_table[$];
	int         err_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	mip_chain_offset_calc_unit #(
		.DIM_BITS    (DIM_W),
		.OFFSET_BITS (OFF_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.level        (level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level_offset (level_offset),
		.level_length (level_length),
		.level_valid  (level_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// byte offset and length of one level, no range or payload check
	function automatic void level_span(input logic [mcoc_pkg::LEVEL_BITS-1:0] lvl,
			output logic [63:0] off, output logic [63:0] len);
		int unsigned w;
		int unsigned h;
		int unsigned side;
		logic [63:0] unit;
		side = (cur_fmt == mcoc_pkg::FMT_BGRA8) ? 1 : 4;
		case (cur_fmt)
			mcoc_pkg::FMT_BC1:   unit = 64'd8;
			mcoc_pkg::FMT_BGRA8: unit = 64'd4;
			default:             unit = 64'd16;
		endcase
		off = '0;
		len = '0;
		for (int i = 0; i <= int'(lvl); i++) begin
			w = 32'(cur_width) >> i;
			h = 32'(cur_height) >> i;
			if (w == 0)
				w = 1;
			if (h == 0)
				h = 1;
			len = 64'((w + side - 1) / side) * 64'((h + side - 1) / side) * unit;
			if (i < int'(lvl))
				off += len;
		end
	endfunction

	function automatic mip_place_t predict_place(
			input logic [mcoc_pkg::LEVEL_BITS-1:0] lvl);
		logic [63:0] off;
		logic [63:0] len;
		mip_place_t  p;
		level_span(lvl, off, len);
		p = '0;
		if (lvl < cur_levels && off + len <= 64'(cur_payload)) begin
			p.off = off[OFF_W-1:0];
			p.len = len[mcoc_pkg::LENGTH_BITS-1:0];
			p.vld = 1'b1;
		end
		return p;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3, 4, 5: return DIM_W'($urandom_range(64, 1));
			default: return DIM_W'($urandom_range(65535, 1));
		endcase
	endfunction

	function automatic stim_row_t row_write(input logic [mcoc_pkg::REG_IDX_BITS-1:0] idx,
			input logic [OFF_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic stim_row_t row_query(input logic [mcoc_pkg::LEVEL_BITS-1:0] lvl);
		stim_row_t r;
		r = '0;
		r.kind = ROW_QUERY;
		r.lvl = lvl;
		return r;
	endfunction

	function automatic stim_row_t row_check(input logic [mcoc_pkg::LEVEL_BITS-1:0] lvl,
			input logic [OFF_W-1:0] off, input logic [mcoc_pkg::LENGTH_BITS-1:0] len,
			input logic vld);
		stim_row_t r;
		r = row_query(lvl);
		r.typed = 1'b1;
		r.want.off = off;
		r.want.len = len;
		r.want.vld = vld;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// called at a falling edge; keeps cfg_we high until the next caller lowers it
	task automatic write_reg(input logic [mcoc_pkg::REG_IDX_BITS-1:0] idx,
			input logic [OFF_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			mcoc_pkg::REG_BASE_WIDTH:    cur_width = data[DIM_W-1:0];
			mcoc_pkg::REG_BASE_HEIGHT:   cur_height = data[DIM_W-1:0];
			mcoc_pkg::REG_PIXEL_FORMAT:  cur_fmt = mcoc_pkg::fmt_t'(data[1:0]);
			mcoc_pkg::REG_LEVEL_COUNT:   cur_levels = data[mcoc_pkg::LEVEL_BITS-1:0];
			mcoc_pkg::REG_PAYLOAD_BYTES: cur_payload = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		do
			@(negedge clk);
		while (place_q.size() != 0);
	endtask

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic send_level(input logic [mcoc_pkg::LEVEL_BITS-1:0] lvl,
			input logic typed, input mip_place_t want);
		cfg_we <= 1'b0;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		level <= lvl;
		do
			@(posedge clk);
		while (!in_ready);
		place_q.insert(place_q.size(), typed ? want : predict_place(lvl));
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (place_q.size() == 0) begin
				report_mismatch("unexpected transaction", 64'(level_offset), 64'd0);
			end else begin
				head = place_q.pop_front();
				if (level_offset !== head.off)
					report_mismatch("level_offset", 64'(level_offset), 64'(head.off));
				if (level_length !== head.len)
					report_mismatch("level_length", 64'(level_length), 64'(head.len));
				if (level_valid !== head.vld)
					report_mismatch("level_valid", 64'(level_valid), 64'(head.vld));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [63:0]                     span_off;
		logic [63:0]                     span_len;
		logic [OFF_W-1:0]                junk;
		logic [OFF_W-1:0]                pay;
		logic [mcoc_pkg::LEVEL_BITS-1:0] lv;

		stim_table = '{
			row_check(5'd0, '0, '0, 1'b0),
			row_check(5'd31, '0, '0, 1'b0),
			row_write(mcoc_pkg::REG_BASE_WIDTH, 36'hFFFF),
			row_write(mcoc_pkg::REG_BASE_HEIGHT, 36'hFFFF),
			row_write(mcoc_pkg::REG_PIXEL_FORMAT, 36'(mcoc_pkg::FMT_BGRA8)),
			row_write(mcoc_pkg::REG_LEVEL_COUNT, 36'd31),
			row_write(mcoc_pkg::REG_PAYLOAD_BYTES, 36'hF_FFFF_FFFF),
			row_check(5'd0, '0, 35'd17179344900, 1'b1),
			row_query(5'd30),
			row_check(5'd31, '0, '0, 1'b0),
			row_write(mcoc_pkg::REG_LEVEL_COUNT, 36'd0),
			row_check(5'd0, '0, '0, 1'b0),
			row_write(mcoc_pkg::REG_LEVEL_COUNT, 36'd31),
			row_write(mcoc_pkg::REG_PIXEL_FORMAT, 36'(mcoc_pkg::FMT_BC1)),
			row_write(mcoc_pkg::REG_BASE_WIDTH, 36'd4),
			row_write(mcoc_pkg::REG_BASE_HEIGHT, 36'd4),
			row_write(mcoc_pkg::REG_PAYLOAD_BYTES, 36'd8),
			row_check(5'd0, '0, 35'd8, 1'b1),
			row_check(5'd1, '0, '0, 1'b0),
			row_write(mcoc_pkg::REG_PAYLOAD_BYTES, 36'd16),
			row_check(5'd1, 36'd8, 35'd8, 1'b1),
			row_write(mcoc_pkg::REG_PAYLOAD_BYTES, 36'd1000),
			row_write(mcoc_pkg::REG_BASE_WIDTH, 36'd8),
			row_write(mcoc_pkg::REG_BASE_HEIGHT, 36'd8),
			row_write(mcoc_pkg::REG_PIXEL_FORMAT, 36'(mcoc_pkg::FMT_BC2)),
			row_check(5'd0, '0, 35'd64, 1'b1),
			row_write(mcoc_pkg::REG_PIXEL_FORMAT, 36'(mcoc_pkg::FMT_BC3)),
			row_check(5'd0, '0, 35'd64, 1'b1),
			// zero sizes clamp to one texel per level
			row_write(mcoc_pkg::REG_BASE_WIDTH, 36'd0),
			row_write(mcoc_pkg::REG_BASE_HEIGHT, 36'd0),
			row_write(mcoc_pkg::REG_PIXEL_FORMAT, 36'(mcoc_pkg::FMT_BGRA8)),
			row_check(5'd5, 36'd20, 35'd4, 1'b1),
			row_check(5'd30, 36'd120, 35'd4, 1'b1),
			row_check(5'd31, '0, '0, 1'b0),
			// upper data bits must be dropped
			row_write(mcoc_pkg::REG_BASE_WIDTH, 36'hF_FFFF_0010),
			row_write(mcoc_pkg::REG_BASE_HEIGHT, 36'hA_5A5A_0004),
			row_write(mcoc_pkg::REG_PIXEL_FORMAT, 36'hF_FFFF_FFFE),
			row_write(mcoc_pkg::REG_LEVEL_COUNT, 36'hF_FFFF_FFE3),
			row_query(5'd0),
			row_query(5'd2),
			row_check(5'd3, '0, '0, 1'b0),
			row_write(REG_IDX_SPARE, 36'hF_FFFF_FFFF),
			row_query(5'd1)
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(stim_table[i].idx, stim_table[i].data);
			end else begin
				send_level(stim_table[i].lvl, stim_table[i].typed, stim_table[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 88;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 88;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase

			junk = 36'({$urandom, $urandom});
			write_reg(mcoc_pkg::REG_BASE_WIDTH, {junk[OFF_W-1:DIM_W], pick_dim()});
			junk = 36'({$urandom, $urandom});
			write_reg(mcoc_pkg::REG_BASE_HEIGHT, {junk[OFF_W-1:DIM_W], pick_dim()});
			junk = 36'({$urandom, $urandom});
			write_reg(mcoc_pkg::REG_PIXEL_FORMAT,
				{junk[OFF_W-1:2], 2'($urandom_range(3))});
			junk = 36'({$urandom, $urandom});
			case ($urandom_range(7))
				0:       lv = '0;
				1:       lv = 5'd31;
				default: lv = 5'($urandom_range(31));
			endcase
			write_reg(mcoc_pkg::REG_LEVEL_COUNT,
				{junk[OFF_W-1:mcoc_pkg::LEVEL_BITS], lv});

			// place the payload end near a level boundary half of the time
			level_span(5'($urandom_range(31)), span_off, span_len);
			span_len = span_off + span_len;
			case ($urandom_range(5))
				0:       pay = span_len[OFF_W-1:0] - 36'd1;
				1:       pay = span_len[OFF_W-1:0];
				2:       pay = span_len[OFF_W-1:0] + 36'($urandom_range(64));
				3:       pay = '1;
				4:       pay = '0;
				default: pay = 36'({$urandom, $urandom});
			endcase
			write_reg(mcoc_pkg::REG_PAYLOAD_BYTES, pay);
			write_reg(REG_IDX_SPARE, 36'({$urandom, $urandom}));

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(9) < 7)
					lv = 5'($urandom_range(cur_levels));
				else
					lv = 5'($urandom_range(31));
				send_level(lv, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		for (int n = 0; n < 5000 && place_q.size() != 0; n++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (place_q.size() != 0)
			report_mismatch("missing transactions", 64'd0, 64'(place_q.size()));

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
